>>> hw/rtl/ohs_pkg.sv
// Shared types and constants for the overwriting history stack.
package ohs_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int RECORD_WIDTH_DEF = 32;

    localparam int REQ_W     = 2;
    localparam int REC_IO_W  = 32;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;

    localparam int S_TDATA_W = ((REC_IO_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((REC_IO_W + CNT_OUT_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_GET  = 2'd2
    } t_req_kind;

    // Per-request outcome handed from the control unit to the result pipeline
    typedef struct packed {
        logic                 ok;
        logic                 rd;
        logic [CNT_OUT_W-1:0] count;
    } t_ctrl_res;

endpackage

>>> hw/rtl/overwriting_history_stack.sv
// Top level of the overwriting history stack: stream ports and result pipeline.
//
// A ring of DEPTH records used as a stack: push stores a record as the newest
// entry and overwrites the oldest one once the ring is full, pop removes and
// returns the newest entry, get returns the entry a given number of steps back
// from the newest without changing anything. Every request gives exactly one
// result carrying ok, the record (zero for push and for failed requests) and
// the count held after the request; request kind 3 is answered with ok=0 and
// changes nothing. The block takes one request per cycle unless a result held
// back on the master side fills both stages. A request updates the pointer and
// issues the access to the record RAM as it transfers; the RAM's registered read
// port and the outcome register form the read stage, and the output register
// follows. The output register and the stage in front of it let a new request
// transfer while a result waits on the master side. The ring is not cleared after
// reset; the pointer and count only ever reach entries that a push has written.
module overwriting_history_stack import ohs_pkg::*; #(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int RECORD_WIDTH = RECORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [31:0] record_in, [35:32] position, [39:36] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]     i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [31:0] fetched_record, [36:32] held_count, [39:37] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // [0] ok
    output logic                 o_m_axis_tuser
);

    localparam int SLOT_W = $clog2(DEPTH);

    logic                    in_accept;
    logic                    s1_move;
    logic                    wr_en, rd_en;
    logic [SLOT_W-1:0]       addr;
    logic [RECORD_WIDTH-1:0] rdata;
    t_ctrl_res               ctrl_res;

    logic                    r_s1_valid;
    t_ctrl_res               r_s1_res;
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [REC_IO_W-1:0]     r_out_rec;
    logic [CNT_OUT_W-1:0]    r_out_cnt;

    // Advance the read stage whenever the output register is free or drains
    assign s1_move         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    ohs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_req_type (i_s_axis_tuser),
        .i_position (i_s_axis_tdata[REC_IO_W +: POS_W]),
        .o_wr_en    (wr_en),
        .o_rd_en    (rd_en),
        .o_addr     (addr),
        .o_res      (ctrl_res)
    );

    // Read data holds while the read stage stalls: no new read issues then
    ohs_ram #(
        .WIDTH (RECORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_re    (rd_en),
        .i_addr  (addr),
        .i_wdata (RECORD_WIDTH'(i_s_axis_tdata[REC_IO_W-1:0])),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture request outcome, then merge the RAM data as the read stage advances
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_res <= ctrl_res;
        end
        if (s1_move) begin
            r_out_ok  <= r_s1_res.ok;
            r_out_cnt <= r_s1_res.count;
            r_out_rec <= r_s1_res.rd ? REC_IO_W'(rdata) : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_cnt, r_out_rec});

`ifndef SYNTHESIS
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> $stable(rdata))
        else $error("record read data changed under a stalled read stage");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_rec == '0))
        else $error("failed request returned a nonzero record");

    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_s1_valid) |=> (r_out_valid && r_s1_valid))
        else $error("request transfer overran the result pipeline");
`endif

endmodule

>>> hw/rtl/ohs_ram.sv
// Generic single-port RAM with registered read.
module ohs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ohs_ctrl.sv
// Pointer and count control: decodes each request and drives the store port.
module ohs_ctrl import ohs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_wr_en,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_addr,
    output t_ctrl_res                o_res
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIFF_W = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [SLOT_W-1:0] r_newest, n_newest;
    logic [CNT_W-1:0]  r_count,  n_count;

    logic [SLOT_W-1:0] slot_inc, slot_dec, get_slot;
    logic [DIFF_W-1:0] diff, diff_wrap;
    logic              wr, rd, ok;

    assign slot_inc = (r_newest == SLOT_W'(DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign slot_dec = (r_newest == '0) ? SLOT_W'(DEPTH - 1) : r_newest - 1'b1;

    // Step back from the newest slot, wrapping around the ring
    assign diff      = DIFF_W'(r_newest) - DIFF_W'(i_position);
    assign diff_wrap = diff[DIFF_W-1] ? diff + DIFF_W'(DEPTH) : diff;
    assign get_slot  = diff_wrap[SLOT_W-1:0];

    always_comb begin
        n_newest = r_newest;
        n_count  = r_count;
        o_addr   = r_newest;
        wr       = 1'b0;
        rd       = 1'b0;
        ok       = 1'b0;
        unique case (i_req_type)
            REQ_PUSH: begin
                n_newest = slot_inc;
                o_addr   = slot_inc;
                wr       = 1'b1;
                ok       = 1'b1;
                if (r_count != CNT_W'(DEPTH)) begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (r_count != '0) begin
                    n_newest = slot_dec;
                    n_count  = r_count - 1'b1;
                    rd       = 1'b1;
                    ok       = 1'b1;
                end
            end
            REQ_GET: begin
                if (CMP_W'(i_position) < CMP_W'(r_count)) begin
                    o_addr = get_slot;
                    rd     = 1'b1;
                    ok     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_newest <= n_newest;
            r_count  <= n_count;
        end
    end

    assign o_wr_en     = i_accept && wr;
    assign o_rd_en     = i_accept && rd;
    assign o_res.ok    = ok;
    assign o_res.rd    = rd;
    assign o_res.count = CNT_OUT_W'(n_count);

endmodule

>>> sim/ohs_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the overwriting history stack: predicts each result and compares it.
module ohs_checker import ohs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [REQ_W-1:0]     i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_m_tuser,
    output int                   o_fail_count,
    output int                   o_pending,
    output logic [CNT_OUT_W-1:0] o_held
);

    typedef struct packed {
        logic                 ok;
        logic [REC_IO_W-1:0]  rec;
        logic [CNT_OUT_W-1:0] cnt;
    } t_answer;

    logic [RECORD_WIDTH_DEF-1:0] ring [DEPTH_DEF];
    int                          newest;
    logic [CNT_OUT_W-1:0]        held;
    t_answer                     answers_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_held       = '0;
        newest       = 0;
        held         = '0;
    end

    // Apply one request to the ring and return the answer it must produce.
    function automatic t_answer serve_request(input logic [REQ_W-1:0] kind,
                                              input logic [REC_IO_W-1:0] rec,
                                              input logic [POS_W-1:0] pos);
        t_answer a;
        int      slot;
        a = '0;
        case (kind)
            REQ_PUSH: begin
                newest       = (newest + 1) % DEPTH_DEF;
                ring[newest] = rec[RECORD_WIDTH_DEF-1:0];
                if (held < DEPTH_DEF)
                    held = held + 1'b1;
                a.ok = 1'b1;
            end
            REQ_POP: begin
                if (held != 0) begin
                    a.ok   = 1'b1;
                    a.rec  = REC_IO_W'(ring[newest]);
                    newest = (newest + DEPTH_DEF - 1) % DEPTH_DEF;
                    held   = held - 1'b1;
                end
            end
            REQ_GET: begin
                if (pos < held) begin
                    slot  = (newest + DEPTH_DEF - (int'(pos) % DEPTH_DEF)) % DEPTH_DEF;
                    a.ok  = 1'b1;
                    a.rec = REC_IO_W'(ring[slot]);
                end
            end
            default: ;
        endcase
        a.cnt = held;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            newest = 0;
            held   = '0;
            answers_due.delete();
        end else begin
            // check the result leaving first; a request never answers in its own cycle
            if (i_m_tvalid && i_m_tready) begin
                if (answers_due.size() == 0) begin
                    $error("result with no request waiting: tdata=%h tuser=%b",
                           i_m_tdata, i_m_tuser);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (i_m_tuser !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, i_m_tuser);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_tdata[REC_IO_W-1:0] !== want.rec) begin
                        $error("fetched_record: expected %h, got %h", want.rec,
                               i_m_tdata[REC_IO_W-1:0]);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_tdata[REC_IO_W +: CNT_OUT_W] !== want.cnt) begin
                        $error("held_count: expected %0d, got %0d", want.cnt,
                               i_m_tdata[REC_IO_W +: CNT_OUT_W]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(serve_request(i_s_tuser, i_s_tdata[REC_IO_W-1:0],
                                                    i_s_tdata[REC_IO_W +: POS_W]));
        end
        o_pending = answers_due.size();
        o_held    = held;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the overwriting history stack, checked by ohs_checker.
module testbench;
    import ohs_pkg::*;

    // request code the block must answer with ok=0 and otherwise ignore
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    // cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT    = 5000;
    localparam int PHASE_ITEMS   = 435;
    localparam int SEGMENT_ITEMS = 40;
    // the block answers through its read stage and output register; leave a margin
    localparam int DRAIN_CYCLES  = 10;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    logic [REQ_W-1:0]     s_tuser    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int                   idle_pct   = 0;
    int                   stall_pct  = 0;
    int                   hang_count = 0;
    int                   fail_count;
    int                   pending;
    logic [CNT_OUT_W-1:0] held_now;

    overwriting_history_stack DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] record_in, [35:32] position, [39:36] zero
        .i_s_axis_tuser  (s_tuser),   // [1:0] req_type
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [31:0] fetched_record, [36:32] held_count, [39:37] zero
        .o_m_axis_tuser  (m_tuser)    // [0] ok
    );

    ohs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_held       (held_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver side: stall at random with the current phase's rate.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one request starting at a falling edge and hold it until the
    // transfer; return at the next falling edge with tvalid still high.
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [REC_IO_W-1:0] rec,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - REC_IO_W - POS_W){1'b0}}, pos, rec};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Drop tvalid and hold off until every answer has come back.
    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Draw one request; push_pct steers the fill level up or down.
    task automatic random_request(input int push_pct);
        logic [REQ_W-1:0]    kind;
        logic [REC_IO_W-1:0] rec;
        logic [POS_W-1:0]    pos;
        int                  roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            kind = REQ_PUSH;
        else if (roll < push_pct + (97 - push_pct) / 2)
            kind = REQ_POP;
        else if (roll < 97)
            kind = REQ_GET;
        else
            kind = REQ_IGNORED;
        case ($urandom_range(9))
            0:       rec = '0;
            1:       rec = '1;
            default: rec = $urandom;
        endcase
        // mostly aim gets at held entries, sometimes anywhere
        if (held_now != 0 && $urandom_range(3) != 0)
            pos = POS_W'($urandom_range(int'(held_now) - 1));
        else
            pos = POS_W'($urandom_range(15));
        send_request(kind, rec, pos);
    endtask

    initial begin
        int push_pct;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty pop and get, ignored code, record extremes,
        // gets inside and past the count, pops down to empty again.
        send_request(REQ_POP, '1, '0);
        send_request(REQ_GET, '1, '0);
        send_request(REQ_IGNORED, '1, '1);
        send_request(REQ_PUSH, '1, '1);
        send_request(REQ_PUSH, '0, '0);
        send_request(REQ_GET, '1, 4'd0);
        send_request(REQ_GET, '0, 4'd1);
        send_request(REQ_GET, '0, 4'd2);
        send_request(REQ_GET, '0, 4'd15);
        send_request(REQ_POP, '0, '0);
        send_request(REQ_POP, '0, '0);
        send_request(REQ_POP, '0, '0);
        send_request(REQ_IGNORED, '0, '0);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            push_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // vary the push bias per segment to sweep empty through overwrite
                if (n % SEGMENT_ITEMS == 0) begin
                    case ($urandom_range(2))
                        0:       push_pct = 20;
                        1:       push_pct = 45;
                        default: push_pct = 80;
                    endcase
                end
                // pause the sender mid-phase until the block has answered everything
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                random_request(push_pct);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ohs_pkg.sv
hw/rtl/ohs_ram.sv
hw/rtl/ohs_ctrl.sv
hw/rtl/overwriting_history_stack.sv
sim/ohs_checker.sv
sim/testbench.sv
